>>> hw/rtl/tdpq_pkg.sv
package tdpq_pkg;

	// Fixed field widths of the command and result channels.
	localparam int unsigned PKT_W = 32;
	localparam int unsigned CNT_OUT_W = 7;
	localparam int unsigned CMD_W = 3;

	// Capacity register: width and value after reset.
	localparam int unsigned CAP_W = 7;
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// Command codes. Codes six and seven act as status without a peak clear.
	typedef enum logic [CMD_W-1:0] {
		CMD_ENQUEUE     = 3'd0,
		CMD_PREPEND     = 3'd1,
		CMD_DEQUEUE     = 3'd2,
		CMD_DEQUEUE_ALL = 3'd3,
		CMD_FLUSH       = 3'd4,
		CMD_STATUS      = 3'd5
	} cmd_code_t;

	// One command request.
	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [PKT_W-1:0] packet;
		logic             peak_reset;
	} cmd_req_t;

	// One result.
	typedef struct packed {
		logic [PKT_W-1:0]     out_packet;
		logic                 out_valid;
		logic                 last;
		logic                 dropped;
		logic [CNT_OUT_W-1:0] freed_count;
		logic [CNT_OUT_W-1:0] queue_size;
		logic [CNT_OUT_W-1:0] peak_size;
		logic [PKT_W-1:0]     head_packet;
		logic                 head_valid;
	} res_t;

endpackage

>>> hw/rtl/tail_drop_packet_queue_unit.sv
// Bounded packet queue with tail drop, held in a ring memory of DEPTH handles.
// The command channel (cmd_valid, cmd_ready, cmd) takes one request: enqueue,
// prepend, dequeue, dequeue all, flush or status. The result channel
// (res_valid, res_ready, res) returns one result per request, or one result
// per held handle for dequeue all, with the final one marked by last.
// The capacity register is written over the APB port; paddr is not decoded.
// Enqueue, prepend, flush and status load the result register at the edge where
// the request is accepted; a dequeue that pops, and each step of dequeue all,
// first waits for the registered memory read of the new head handle. The head
// handle is cached in a register, so only a pop needs a memory read. One request
// per cycle while results drain, but a popping dequeue holds off new requests
// until done; dequeue all yields one handle per cycle while results drain.
// A request is taken while a result still waits, as long as the result
// register is drained in the same cycle. When the receiver stalls, the result
// holds and no new request is taken.
// Reset empties the queue, clears the peak counter and sets capacity to 64;
// the memory contents are not cleared and need no clearing pass.
module tail_drop_packet_queue_unit
	import tdpq_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned HANDLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_req_t    cmd,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       head_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       peak_q;
	logic [CAP_W-1:0]       capacity_q;
	logic                   run_all_q;
	logic [HANDLE_BITS-1:0] head_pkt_q;
	logic [HANDLE_BITS-1:0] taken_q;
	logic                   res_valid_q;
	res_t                   res_q;

	logic [HANDLE_BITS-1:0] mem [DEPTH];
	logic [HANDLE_BITS-1:0] rd_data_q;

	logic                   res_free;
	logic                   cmd_fire;
	logic [HANDLE_BITS-1:0] pkt_in;
	logic [IDX_W-1:0]       head_inc;
	logic [IDX_W-1:0]       head_dec;
	logic [IDX_W:0]         tail_sum;
	logic [IDX_W-1:0]       tail_idx;
	logic                   ring_full;
	logic                   cap_hit;
	logic [CNT_W-1:0]       count_inc;

	state_t                 state_d;
	logic [IDX_W-1:0]       head_d;
	logic [CNT_W-1:0]       count_d;
	logic [CNT_W-1:0]       peak_d;
	logic                   run_all_d;
	logic [HANDLE_BITS-1:0] head_pkt_d;
	logic [HANDLE_BITS-1:0] taken_d;
	logic                   res_load;
	res_t                   res_d;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic                   rd_en;

	// Handshake.
	assign res_free  = !res_valid_q || res_ready;
	assign cmd_ready = (state_q == ST_IDLE) && res_free;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Configuration port.
	assign pready = 1'b1;
	assign prdata = 32'(capacity_q);

	// Ring index arithmetic; the tail sum stays below twice the depth.
	assign pkt_in    = HANDLE_BITS'(cmd.packet);
	assign head_inc  = (head_q == IDX_LAST) ? '0 : head_q + 1'b1;
	assign head_dec  = (head_q == '0) ? IDX_LAST : head_q - 1'b1;
	assign tail_sum  = {1'b0, head_q} + {1'b0, count_q[IDX_W-1:0]};
	assign tail_idx  = (tail_sum >= (IDX_W+1)'(DEPTH)) ?
		IDX_W'(tail_sum - (IDX_W+1)'(DEPTH)) : tail_sum[IDX_W-1:0];
	assign ring_full = (count_q >= CNT_FULL);
	assign cap_hit   = (CMP_W'(count_q) >= CMP_W'(capacity_q));
	assign count_inc = count_q + 1'b1;

	// Next-state and result formation.
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		peak_d     = peak_q;
		run_all_d  = run_all_q;
		head_pkt_d = head_pkt_q;
		taken_d    = taken_q;
		res_load   = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = tail_idx;
		rd_en      = 1'b0;
		res_d      = '0;
		res_d.last = 1'b1;
		if (state_q == ST_IDLE) begin
			if (cmd_fire) begin
				res_load = 1'b1;
				res_d.peak_size = CNT_OUT_W'(peak_q);
				case (cmd.command)
					CMD_ENQUEUE: begin
						if (cap_hit || ring_full) begin
							res_d.dropped = 1'b1;
						end else begin
							wr_en   = 1'b1;
							wr_addr = tail_idx;
							count_d = count_inc;
							if (count_inc > peak_q) begin
								peak_d = count_inc;
							end
							if (count_q == '0) begin
								head_pkt_d = pkt_in;
							end
							res_d.peak_size = CNT_OUT_W'(peak_d);
						end
					end
					CMD_PREPEND: begin
						if (ring_full) begin
							res_d.dropped = 1'b1;
						end else begin
							wr_en      = 1'b1;
							wr_addr    = head_dec;
							head_d     = head_dec;
							count_d    = count_inc;
							head_pkt_d = pkt_in;
						end
					end
					CMD_DEQUEUE, CMD_DEQUEUE_ALL: begin
						// A pop needs the new head from memory first.
						if (count_q != '0) begin
							res_load  = 1'b0;
							rd_en     = 1'b1;
							taken_d   = head_pkt_q;
							head_d    = head_inc;
							count_d   = count_q - 1'b1;
							run_all_d = (cmd.command == CMD_DEQUEUE_ALL);
							state_d   = ST_POP;
						end
					end
					CMD_FLUSH: begin
						res_d.freed_count = CNT_OUT_W'(count_q);
						count_d = '0;
						head_d  = '0;
					end
					CMD_STATUS: begin
						if (cmd.peak_reset) begin
							peak_d = '0;
						end
					end
					default: begin
					end
				endcase
				res_d.queue_size  = CNT_OUT_W'(count_d);
				res_d.head_valid  = (count_d != '0);
				res_d.head_packet = (count_d != '0) ? PKT_W'(head_pkt_d) : '0;
			end
		end else begin
			// Deliver the popped handle once the result register is free.
			if (res_free) begin
				res_load          = 1'b1;
				head_pkt_d        = rd_data_q;
				res_d.out_packet  = PKT_W'(taken_q);
				res_d.out_valid   = 1'b1;
				res_d.peak_size   = CNT_OUT_W'(peak_q);
				res_d.queue_size  = CNT_OUT_W'(count_q);
				res_d.head_valid  = (count_q != '0);
				res_d.head_packet = (count_q != '0) ? PKT_W'(rd_data_q) : '0;
				if (run_all_q && (count_q != '0)) begin
					// Next step of the run: pop again right away.
					res_d.last = 1'b0;
					rd_en      = 1'b1;
					taken_d    = rd_data_q;
					head_d     = head_inc;
					count_d    = count_q - 1'b1;
				end else begin
					state_d = ST_IDLE;
				end
			end
		end
	end

	// State, control and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			peak_q      <= '0;
			capacity_q  <= CAP_RESET;
			run_all_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			count_q   <= count_d;
			peak_q    <= peak_d;
			run_all_q <= run_all_d;
			if (psel && penable && pwrite) begin
				capacity_q <= pwdata[CAP_W-1:0];
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		head_pkt_q <= head_pkt_d;
		taken_q    <= taken_d;
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// Ring memory: one write port, one registered read port at the next head.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= pkt_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[head_inc];
		end
	end

endmodule
